// ===== hdl/bivariate_poly_eval_defines.svh =====
// assertion macros used by the checker file
`ifndef BIVARIATE_POLY_EVAL_DEFINES_SVH
`define BIVARIATE_POLY_EVAL_DEFINES_SVH

// property checked on every clock edge outside reset
`define BPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BPE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bpe_pkg.sv =====
// types, constants and term ordering tables of the polynomial evaluator
package bpe_pkg;

	localparam int MaxTermsDef = 55;
	localparam int NumMono     = 55;
	localparam int MaxDeg      = 9;
	localparam int DegW        = 4;
	localparam int IdxW        = 6;
	localparam int CoefW       = 32;
	localparam int XyW         = 16;
	localparam int MonoW       = 32;
	localparam int ProdW       = MonoW + XyW;
	localparam int TprodW      = CoefW + MonoW;
	localparam int TermW       = 34;
	localparam int AccW        = 50;
	localparam int ValW        = 48;
	localparam int PaddrW      = 3;
	localparam int PdataW      = 32;

	localparam logic [IdxW-1:0]   NoMono     = '1;
	localparam logic [7:0]        NoTerm     = 8'hFF;
	localparam logic [PaddrW-1:0] RegDegAddr = PaddrW'(0);

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FILL   = 5'b00010,
		ST_TERM   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic            xy_load;
		logic            coef_we;
		logic            fill_init;
		logic            fill_step;
		logic            fill_row;
		logic [IdxW-1:0] mono_waddr;
		logic            term_rd;
		logic [IdxW-1:0] term_slot;
		logic [IdxW-1:0] term_mono;
		logic            acc_clear;
		logic            out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// first monomial index of each x exponent row, rows ordered by x then y
	localparam logic [IdxW-1:0] RowBase [10] = '{
		6'd0, 6'd10, 6'd19, 6'd27, 6'd34, 6'd40, 6'd45, 6'd49, 6'd52, 6'd54
	};

	localparam logic [IdxW-1:0] TermCnt [10] = '{
		6'd1, 6'd3, 6'd6, 6'd10, 6'd15, 6'd22, 6'd28, 6'd36, 6'd45, 6'd55
	};

	// term order shared by degrees 0 to 5, entry 0xab is x^a y^b
	localparam logic [7:0] Ord05 [22] = '{
		8'h00,8'h10,8'h01,8'h11,8'h20,8'h02,8'h12,8'h21,8'h30,8'h03,8'h22,
		8'h13,8'h31,8'h40,8'h04,8'h23,8'h32,8'h14,8'h41,8'h50,8'h05,8'hFF
	};

	localparam logic [7:0] Ord6 [28] = '{
		8'h00,8'h10,8'h01,8'h12,8'h11,8'h20,8'h02,8'h30,8'h03,8'h21,8'h13,
		8'h31,8'h22,8'h40,8'h04,8'h60,8'h06,8'h24,8'h42,8'h15,8'h51,8'h33,
		8'h23,8'h32,8'h14,8'h41,8'h05,8'h50
	};

	localparam logic [7:0] Ord7 [36] = '{
		8'h00,8'h10,8'h01,8'h12,8'h11,8'h20,8'h02,8'h30,8'h03,8'h21,8'h13,
		8'h31,8'h22,8'h40,8'h04,8'h60,8'h06,8'h24,8'h42,8'h15,8'h51,8'h33,
		8'h70,8'h07,8'h43,8'h25,8'h52,8'h16,8'h61,8'h23,8'h32,8'h14,8'h41,
		8'h34,8'h05,8'h50
	};

	localparam logic [7:0] Ord8 [45] = '{
		8'h00,8'h10,8'h01,8'h12,8'h11,8'h20,8'h02,8'h30,8'h03,8'h21,8'h71,
		8'h62,8'h17,8'h26,8'h13,8'h31,8'h22,8'h40,8'h04,8'h60,8'h06,8'h44,
		8'h24,8'h42,8'h15,8'h51,8'h33,8'h70,8'h07,8'h35,8'h43,8'h25,8'h52,
		8'h16,8'h61,8'h23,8'h32,8'h14,8'h41,8'h34,8'h05,8'h50,8'h53,8'h80,
		8'h08
	};

	localparam logic [7:0] Ord9 [55] = '{
		8'h00,8'h10,8'h01,8'h12,8'h11,8'h20,8'h02,8'h30,8'h03,8'h21,8'h71,
		8'h62,8'h17,8'h26,8'h27,8'h90,8'h09,8'h13,8'h31,8'h22,8'h40,8'h04,
		8'h60,8'h06,8'h44,8'h24,8'h42,8'h15,8'h51,8'h33,8'h70,8'h07,8'h35,
		8'h43,8'h25,8'h52,8'h16,8'h61,8'h23,8'h32,8'h14,8'h41,8'h34,8'h05,
		8'h50,8'h53,8'h18,8'h63,8'h45,8'h54,8'h36,8'h72,8'h81,8'h80,8'h08
	};

	// number of slots for a degree, none for degrees without meaning
	function automatic logic [IdxW-1:0] term_count(input logic [DegW-1:0] deg);
		logic [IdxW-1:0] n;
		n = '0;
		if (deg <= DegW'(MaxDeg)) begin
			n = TermCnt[deg];
		end
		return n;
	endfunction

	// monomial index used by slot k of a degree, NoMono for an empty slot
	function automatic logic [IdxW-1:0] slot_mono(input logic [DegW-1:0] deg,
		input logic [IdxW-1:0] k);
		logic [7:0]      t;
		logic [IdxW-1:0] m;
		t = NoTerm;
		m = NoMono;
		priority if (deg <= DegW'(5)) begin
			if (k < IdxW'(22)) t = Ord05[k[4:0]];
		end else if (deg == DegW'(6)) begin
			if (k < IdxW'(28)) t = Ord6[k[4:0]];
		end else if (deg == DegW'(7)) begin
			if (k < IdxW'(36)) t = Ord7[k];
		end else if (deg == DegW'(8)) begin
			if (k < IdxW'(45)) t = Ord8[k];
		end else if (deg == DegW'(9)) begin
			if (k < IdxW'(55)) t = Ord9[k];
		end else begin
			t = NoTerm;
		end
		if (t != NoTerm) begin
			m = RowBase[t[7:4]] + {2'b00, t[3:0]};
		end
		return m;
	endfunction

endpackage

// ===== hdl/bpe_dp.sv =====
// datapath: coefficient and monomial memories, multipliers, accumulator, result register
module bpe_dp #(
	parameter int MAX_TERMS = bpe_pkg::MaxTermsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpe_pkg::dp_cmd_t               dp_cmd,
	input  logic signed [bpe_pkg::XyW-1:0]   x_norm,
	input  logic signed [bpe_pkg::XyW-1:0]   y_norm,
	input  logic [bpe_pkg::IdxW-1:0]         coef_index,
	input  logic signed [bpe_pkg::CoefW-1:0] coef_value,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic signed [bpe_pkg::ValW-1:0]  poly_value,
	output logic                           saturated,
	output bpe_pkg::dp_stat_t              dp_stat
);
	import bpe_pkg::*;

	localparam int CIdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic signed [MonoW-1:0] MonoOne = MonoW'(1) << 30;
	localparam logic signed [AccW-1:0]  SatHi =
		{{(AccW-ValW+1){1'b0}}, {(ValW-1){1'b1}}};
	localparam logic signed [AccW-1:0]  SatLo = ~SatHi;

	logic signed [XyW-1:0]    x_q, y_q;
	logic signed [MonoW-1:0]  cur_q, head_q;
	logic signed [MonoW-1:0]  m_op;
	logic signed [XyW-1:0]    v_op;
	logic signed [ProdW-1:0]  mprod, mrnd;
	logic signed [MonoW-1:0]  mono_nxt;

	logic signed [CoefW-1:0]  coef_mem [MAX_TERMS];
	logic signed [MonoW-1:0]  mono_mem [NumMono];

	logic signed [CoefW-1:0]  coef_s1;
	logic signed [MonoW-1:0]  mono_s1;
	logic                     valid_s1;
	logic signed [TprodW-1:0] prod_s2;
	logic                     valid_s2;
	logic signed [TprodW-1:0] tsum, tsh;
	logic signed [TermW-1:0]  term;
	logic signed [AccW-1:0]   acc_q;

	logic signed [ValW-1:0]   clip_val;
	logic                     clip_sat;
	logic                     out_valid_q;
	logic signed [ValW-1:0]   poly_q;
	logic                     sat_q;

	// coordinates of the evaluate request
	always_ff @(posedge clk) begin
		if (dp_cmd.xy_load) begin
			x_q <= x_norm;
			y_q <= y_norm;
		end
	end

	// shared monomial multiplier with round to nearest
	assign m_op     = dp_cmd.fill_row ? head_q : cur_q;
	assign v_op     = dp_cmd.fill_row ? x_q : y_q;
	assign mprod    = m_op * v_op;
	assign mrnd     = (mprod + ProdW'(16384)) >>> 15;
	assign mono_nxt = mrnd[MonoW-1:0];

	// running monomial and start of the current row
	always_ff @(posedge clk) begin
		if (dp_cmd.fill_init) begin
			cur_q  <= MonoOne;
			head_q <= MonoOne;
		end else if (dp_cmd.fill_step) begin
			cur_q <= mono_nxt;
			if (dp_cmd.fill_row) begin
				head_q <= mono_nxt;
			end
		end
	end

	// monomial memory
	always_ff @(posedge clk) begin
		if (dp_cmd.fill_step) begin
			mono_mem[dp_cmd.mono_waddr] <= cur_q;
		end
	end

	// coefficient memory, writes beyond the table are dropped
	always_ff @(posedge clk) begin
		if (dp_cmd.coef_we && (coef_index < IdxW'(MAX_TERMS))) begin
			coef_mem[coef_index[CIdxW-1:0]] <= coef_value;
		end
	end

	// term read stage
	always_ff @(posedge clk) begin
		if (dp_cmd.term_rd) begin
			coef_s1 <= coef_mem[dp_cmd.term_slot[CIdxW-1:0]];
			mono_s1 <= mono_mem[dp_cmd.term_mono];
		end
	end

	// term product stage
	always_ff @(posedge clk) begin
		prod_s2 <= coef_s1 * mono_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= dp_cmd.term_rd;
			valid_s2 <= valid_s1;
		end
	end

	// round term to Q.16 and accumulate
	assign tsum = prod_s2 + TprodW'(64'sd536870912);
	assign tsh  = tsum >>> 30;
	assign term = tsh[TermW-1:0];

	always_ff @(posedge clk) begin
		if (dp_cmd.acc_clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + AccW'(term);
		end
	end

	// saturate to the result width
	always_comb begin
		clip_sat = 1'b0;
		clip_val = acc_q[ValW-1:0];
		priority if (acc_q > SatHi) begin
			clip_val = SatHi[ValW-1:0];
			clip_sat = 1'b1;
		end else if (acc_q < SatLo) begin
			clip_val = SatLo[ValW-1:0];
			clip_sat = 1'b1;
		end else begin
			clip_sat = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			poly_q <= clip_val;
			sat_q  <= clip_sat;
		end
	end

	assign out_valid        = out_valid_q;
	assign poly_value       = poly_q;
	assign saturated        = sat_q;
	assign dp_stat.out_free = !out_valid_q || out_ready;

endmodule

// ===== hdl/bpe_ctrl.sv =====
// controller: request handshake, degree register and evaluation sequencer
module bpe_ctrl #(
	parameter int MAX_TERMS = bpe_pkg::MaxTermsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpe_pkg::PaddrW-1:0]    paddr,
	input  logic [bpe_pkg::PdataW-1:0]    pwdata,
	output logic [bpe_pkg::PdataW-1:0]    prdata,
	input  bpe_pkg::dp_stat_t             dp_stat,
	output bpe_pkg::dp_cmd_t              dp_cmd
);
	import bpe_pkg::*;

	state_t          state_q, state_nxt;
	logic [DegW-1:0] deg_q;
	logic [DegW-1:0] a_q, b_q;
	logic [IdxW-1:0] widx_q, k_q, n_q;
	logic            drain_q;
	logic            accept;
	logic            row_end;
	logic [IdxW-1:0] k_mono;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign row_end  = (b_q == (DegW'(MaxDeg) - a_q));
	assign k_mono   = slot_mono(deg_q, k_q);

	// degree register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= '0;
		end else if (psel && penable && pwrite && (paddr == RegDegAddr)) begin
			deg_q <= pwdata[DegW-1:0];
		end
	end

	assign prdata = (paddr == RegDegAddr) ? PdataW'(deg_q) : '0;

	// next state and datapath commands
	always_comb begin
		state_nxt         = state_q;
		dp_cmd            = '0;
		dp_cmd.fill_row   = row_end;
		dp_cmd.mono_waddr = widx_q;
		dp_cmd.term_slot  = k_q;
		dp_cmd.term_mono  = k_mono;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd) begin
						dp_cmd.coef_we = 1'b1;
					end else begin
						dp_cmd.xy_load   = 1'b1;
						dp_cmd.fill_init = 1'b1;
						dp_cmd.acc_clear = 1'b1;
						state_nxt        = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				dp_cmd.fill_step = 1'b1;
				if (widx_q == IdxW'(NumMono - 1)) begin
					state_nxt = (n_q != '0) ? ST_TERM : ST_DRAIN;
				end
			end
			ST_TERM: begin
				dp_cmd.term_rd = (k_mono != NoMono) && (k_q < IdxW'(MAX_TERMS));
				if (k_q == (n_q - IdxW'(1))) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (dp_stat.out_free) begin
					dp_cmd.out_load = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= '0;
			b_q     <= '0;
			widx_q  <= '0;
			k_q     <= '0;
			n_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					a_q     <= '0;
					b_q     <= '0;
					widx_q  <= '0;
					k_q     <= '0;
					drain_q <= 1'b0;
					n_q     <= term_count(deg_q);
				end
				ST_FILL: begin
					widx_q <= widx_q + IdxW'(1);
					if (row_end) begin
						a_q <= a_q + DegW'(1);
						b_q <= '0;
					end else begin
						b_q <= b_q + DegW'(1);
					end
				end
				ST_TERM: begin
					k_q <= k_q + IdxW'(1);
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
				end
				ST_FINISH: begin
					drain_q <= 1'b0;
				end
				default: begin
					drain_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/bivariate_poly_eval.sv =====
// top level of the bivariate polynomial evaluator
//
// Requests enter on in_valid/in_ready. A write request (cmd 1) stores
// coef_value in slot coef_index and gives no result; slots at or beyond
// MAX_TERMS are dropped. An evaluate request (cmd 0) gives one result on
// out_valid/out_ready: the sum of coefficient times x^a*y^b over the
// slots of the selected degree, saturated to 48 bits.
// The degree register sits at APB address 0 and is to be written by the
// user only while idle; the block does not enforce this. An evaluation
// first builds all 55 monomials of degree up to 9 with one 32x16
// multiplier, one a cycle, then walks the n slots of the degree through a
// 32x32 multiply-accumulate pipeline of three stages (n = 1 to 55 slots,
// 0 for degrees 10 to 15). No new request is taken until the result of an
// evaluate request has been loaded into the result register.
// Write requests are taken every cycle while idle, also while a result waits.
// If the receiver stalls, the result is held and the next evaluation waits
// before loading its own result.
// Reset clears control state and the degree; coefficients must be written
// before they are used.
module bivariate_poly_eval #(
	parameter int MAX_TERMS = bpe_pkg::MaxTermsDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic signed [bpe_pkg::XyW-1:0]   x_norm,
	input  logic signed [bpe_pkg::XyW-1:0]   y_norm,
	input  logic [bpe_pkg::IdxW-1:0]         coef_index,
	input  logic signed [bpe_pkg::CoefW-1:0] coef_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [bpe_pkg::ValW-1:0]  poly_value,
	output logic                             saturated,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bpe_pkg::PaddrW-1:0]       paddr,
	input  logic [bpe_pkg::PdataW-1:0]       pwdata,
	output logic [bpe_pkg::PdataW-1:0]       prdata,
	output logic                             pready
);
	import bpe_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// register port never waits
	assign pready = 1'b1;

	// sequencer
	bpe_ctrl #(
		.MAX_TERMS (MAX_TERMS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.dp_stat  (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	// arithmetic and storage
	bpe_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.x_norm     (x_norm),
		.y_norm     (y_norm),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.poly_value (poly_value),
		.saturated  (saturated),
		.dp_stat    (dp_stat)
	);

endmodule

// ===== hdl/bpe_checker.sv =====
// port checker of the polynomial evaluator and its bind
`include "bivariate_poly_eval_defines.svh"

module bpe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             cmd,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [bpe_pkg::ValW-1:0]  poly_value,
	input logic                             saturated
);

	// a stalled result stays put
	`BPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(poly_value), "result dropped or changed while stalled")

	// a clipped result sits at one end of the range
	`BPE_ASSERT(a_sat_edge, out_valid && saturated |-> poly_value == 48'sh7FFF_FFFF_FFFF || poly_value == 48'sh8000_0000_0000, "clipped result not at range limit")

	// an evaluate request keeps the block busy
	`BPE_ASSERT(a_eval_busy, in_valid && in_ready && !cmd |=> !in_ready, "request taken during evaluation")

	// a coefficient write never brings up a result
	`BPE_ASSERT(a_write_quiet, in_valid && in_ready && cmd && !out_valid |=> !out_valid, "result after coefficient write")

	// nothing is offered during reset
	`BPE_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind bivariate_poly_eval bpe_checker u_bpe_checker (.*);
